/* rtl/core/pgba_pkg.sv */
// shared types and constants for the pair group-by aggregation block
package pgba_pkg;

   localparam int TABLE_DEPTH_DEF = 512;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_ACCUM = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam logic [15:0] CNT_MAX = 16'hFFFF;
   localparam logic [31:0] EN_MAX  = 32'hFFFF_FFFF;
   localparam logic [47:0] REV_MAX = 48'hFFFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      RSP_NEW        = 3'd0,
      RSP_UPDATED    = 3'd1,
      RSP_FULL       = 3'd2,
      RSP_CLEARED    = 3'd3,
      RSP_READ_OK    = 3'd4,
      RSP_READ_RANGE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      OP_CLEAR,
      OP_ACCUM,
      OP_READ
   } op_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_SCAN_RD,
      ENG_SCAN_CMP,
      ENG_WRITE,
      ENG_APPEND,
      ENG_READ_CHK,
      ENG_READ_WAIT
   } eng_state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [23:0] energy;
      logic [15:0] price;
      logic [8:0]  read_index;
   } cmd_type;

endpackage

/* rtl/core/pgba_if.sv */
// request and response channel interfaces
interface pgba_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [15:0] buyer_id;
   logic [15:0] seller_id;
   logic [23:0] energy;
   logic [15:0] price;
   logic [8:0]  read_index;

   modport source (output valid, action, buyer_id, seller_id, energy, price, read_index,
                   input ready);
   modport sink   (input valid, action, buyer_id, seller_id, energy, price, read_index,
                   output ready);
endinterface

interface pgba_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [8:0]  entry_index;
   logic [9:0]  pair_total;
   logic [15:0] entry_buyer;
   logic [15:0] entry_seller;
   logic [15:0] entry_count;
   logic [31:0] entry_energy;
   logic [47:0] entry_revenue;
   logic [15:0] best_buyer;
   logic [15:0] best_seller;
   logic [15:0] best_count;

   modport source (output valid, status, entry_index, pair_total, entry_buyer, entry_seller,
                   entry_count, entry_energy, entry_revenue, best_buyer, best_seller,
                   best_count,
                   input ready);
   modport sink   (input valid, status, entry_index, pair_total, entry_buyer, entry_seller,
                   entry_count, entry_energy, entry_revenue, best_buyer, best_seller,
                   best_count,
                   output ready);
endinterface

/* rtl/core/pgba_front.sv */
// request intake, action decode and two-entry command queue
module pgba_front (
   input  logic            clock,
   input  logic            reset,
   pgba_req_if.sink        req_ch,
   output logic            cmd_valid,
   output pgba_pkg::cmd_type cmd,
   input  logic            cmd_pop
);

   pgba_pkg::cmd_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   pgba_pkg::cmd_type dec;
   logic              push;

   always_comb begin
      dec.key        = {req_ch.buyer_id, req_ch.seller_id};
      dec.energy     = req_ch.energy;
      dec.price      = req_ch.price;
      dec.read_index = req_ch.read_index;
      case (req_ch.action) inside
         pgba_pkg::ACT_CLEAR: dec.op = pgba_pkg::OP_CLEAR;
         pgba_pkg::ACT_ACCUM: dec.op = pgba_pkg::OP_ACCUM;
         default:             dec.op = pgba_pkg::OP_READ;
      endcase
   end

   assign req_ch.ready = (cnt_ff != 2'd2);
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (cnt_ff != 2'd0);
   assign cmd          = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/core/pgba_back.sv */
// aggregation engine: table scan, read-modify-write, best pair and response register
module pgba_back #(
   parameter int TABLE_DEPTH = pgba_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  pgba_pkg::cmd_type cmd,
   output logic              cmd_pop,
   pgba_rsp_if.source        rsp_ch
);

   localparam int IW   = $clog2(TABLE_DEPTH);
   localparam int SW   = IW + 1;
   localparam int CMPW = (SW > 10) ? SW : 10;

   logic [31:0] key_mem [TABLE_DEPTH];
   logic [15:0] cnt_mem [TABLE_DEPTH];
   logic [31:0] en_mem  [TABLE_DEPTH];
   logic [47:0] rev_mem [TABLE_DEPTH];

   pgba_pkg::eng_state_type state_ff, state_in;
   pgba_pkg::cmd_type       cmd_ff, cmd_in;
   logic [39:0] prod_ff, prod_in;
   logic [SW-1:0] scan_ff, scan_in;
   logic [SW-1:0] stored_ff, stored_in;
   logic [15:0] best_total_ff, best_total_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [31:0] best_key_ff, best_key_in;
   logic [15:0] nc_ff, nc_in;
   logic [31:0] ne_ff, ne_in;
   logic [47:0] nr_ff, nr_in;
   logic [31:0] key_rd_ff;
   logic [15:0] cnt_rd_ff;
   logic [31:0] en_rd_ff;
   logic [47:0] rev_rd_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  st_ff, st_in;
   logic [8:0]  eidx_ff, eidx_in;
   logic [31:0] ekey_ff, ekey_in;
   logic [15:0] ecnt_ff, ecnt_in;
   logic [31:0] een_ff, een_in;
   logic [47:0] erev_ff, erev_in;

   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_key, wr_en_sum;
   logic [15:0]   wr_cnt;
   logic [47:0]   wr_rev;
   logic          cons_en;
   logic [IW-1:0] cons_idx;
   logic [15:0]   cons_cnt;
   logic [31:0]   cons_key;

   logic        scan_miss, table_full, hit, read_ok;
   logic [32:0] en_add;
   logic [48:0] rev_add;

   assign scan_miss  = (scan_ff >= stored_ff);
   assign table_full = (stored_ff == SW'(TABLE_DEPTH));
   assign hit        = (key_rd_ff == cmd_ff.key);
   assign read_ok    = (CMPW'(cmd_ff.read_index) < CMPW'(stored_ff));
   assign en_add     = {1'b0, en_rd_ff} + {9'd0, cmd_ff.energy};
   assign rev_add    = {1'b0, rev_rd_ff} + {9'd0, prod_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgba_pkg::ENG_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               case (cmd.op)
                  pgba_pkg::OP_CLEAR: state_in = pgba_pkg::ENG_IDLE;
                  pgba_pkg::OP_ACCUM: state_in = pgba_pkg::ENG_SCAN_RD;
                  default:            state_in = pgba_pkg::ENG_READ_CHK;
               endcase
            end
         end
         pgba_pkg::ENG_SCAN_RD: begin
            if (!scan_miss) state_in = pgba_pkg::ENG_SCAN_CMP;
            else if (table_full) state_in = pgba_pkg::ENG_IDLE;
            else state_in = pgba_pkg::ENG_APPEND;
         end
         pgba_pkg::ENG_SCAN_CMP: begin
            state_in = hit ? pgba_pkg::ENG_WRITE : pgba_pkg::ENG_SCAN_RD;
         end
         pgba_pkg::ENG_READ_CHK: begin
            state_in = read_ok ? pgba_pkg::ENG_READ_WAIT : pgba_pkg::ENG_IDLE;
         end
         default: state_in = pgba_pkg::ENG_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in       = cmd_ff;
      prod_in      = prod_ff;
      scan_in      = scan_ff;
      stored_in    = stored_ff;
      nc_in        = nc_ff;
      ne_in        = ne_ff;
      nr_in        = nr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      st_in        = st_ff;
      eidx_in      = eidx_ff;
      ekey_in      = ekey_ff;
      ecnt_in      = ecnt_ff;
      een_in       = een_ff;
      erev_in      = erev_ff;
      cmd_pop      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_key       = '0;
      wr_cnt       = '0;
      wr_en_sum    = '0;
      wr_rev       = '0;
      cons_en      = 1'b0;
      cons_idx     = '0;
      cons_cnt     = '0;
      cons_key     = '0;
      case (state_ff)
         pgba_pkg::ENG_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               scan_in = '0;
               if (cmd.op == pgba_pkg::OP_CLEAR) begin
                  stored_in    = '0;
                  st_in        = pgba_pkg::RSP_CLEARED;
                  eidx_in      = '0;
                  ekey_in      = '0;
                  ecnt_in      = '0;
                  een_in       = '0;
                  erev_in      = '0;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         pgba_pkg::ENG_SCAN_RD: begin
            prod_in = cmd_ff.energy * cmd_ff.price;
            if (!scan_miss) begin
               rd_en   = 1'b1;
               rd_addr = scan_ff[IW-1:0];
            end else if (table_full) begin
               st_in        = pgba_pkg::RSP_FULL;
               eidx_in      = '0;
               ekey_in      = '0;
               ecnt_in      = '0;
               een_in       = '0;
               erev_in      = '0;
               rsp_valid_in = 1'b1;
            end
         end
         pgba_pkg::ENG_SCAN_CMP: begin
            if (hit) begin
               nc_in = (cnt_rd_ff == pgba_pkg::CNT_MAX) ? cnt_rd_ff : cnt_rd_ff + 16'd1;
               ne_in = en_add[32] ? pgba_pkg::EN_MAX : en_add[31:0];
               nr_in = rev_add[48] ? pgba_pkg::REV_MAX : rev_add[47:0];
            end else begin
               scan_in = scan_ff + SW'(1);
            end
         end
         pgba_pkg::ENG_WRITE: begin
            wr_en        = 1'b1;
            wr_addr      = scan_ff[IW-1:0];
            wr_key       = cmd_ff.key;
            wr_cnt       = nc_ff;
            wr_en_sum    = ne_ff;
            wr_rev       = nr_ff;
            cons_en      = 1'b1;
            cons_idx     = scan_ff[IW-1:0];
            cons_cnt     = nc_ff;
            cons_key     = cmd_ff.key;
            st_in        = pgba_pkg::RSP_UPDATED;
            eidx_in      = 9'(scan_ff[IW-1:0]);
            ekey_in      = cmd_ff.key;
            ecnt_in      = nc_ff;
            een_in       = ne_ff;
            erev_in      = nr_ff;
            rsp_valid_in = 1'b1;
         end
         pgba_pkg::ENG_APPEND: begin
            wr_en        = 1'b1;
            wr_addr      = stored_ff[IW-1:0];
            wr_key       = cmd_ff.key;
            wr_cnt       = 16'd1;
            wr_en_sum    = 32'(cmd_ff.energy);
            wr_rev       = 48'(prod_ff);
            stored_in    = stored_ff + SW'(1);
            cons_en      = 1'b1;
            cons_idx     = stored_ff[IW-1:0];
            cons_cnt     = 16'd1;
            cons_key     = cmd_ff.key;
            st_in        = pgba_pkg::RSP_NEW;
            eidx_in      = 9'(stored_ff[IW-1:0]);
            ekey_in      = cmd_ff.key;
            ecnt_in      = 16'd1;
            een_in       = 32'(cmd_ff.energy);
            erev_in      = 48'(prod_ff);
            rsp_valid_in = 1'b1;
         end
         pgba_pkg::ENG_READ_CHK: begin
            if (read_ok) begin
               rd_en   = 1'b1;
               rd_addr = IW'(cmd_ff.read_index);
            end else begin
               st_in        = pgba_pkg::RSP_READ_RANGE;
               eidx_in      = cmd_ff.read_index;
               ekey_in      = '0;
               ecnt_in      = '0;
               een_in       = '0;
               erev_in      = '0;
               rsp_valid_in = 1'b1;
            end
         end
         pgba_pkg::ENG_READ_WAIT: begin
            st_in        = pgba_pkg::RSP_READ_OK;
            eidx_in      = cmd_ff.read_index;
            ekey_in      = key_rd_ff;
            ecnt_in      = cnt_rd_ff;
            een_in       = en_rd_ff;
            erev_in      = rev_rd_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // best pair tracking
   always_comb begin
      best_total_in = best_total_ff;
      best_idx_in   = best_idx_ff;
      best_key_in   = best_key_ff;
      if (cmd_pop && cmd.op == pgba_pkg::OP_CLEAR) begin
         best_total_in = '0;
         best_idx_in   = '0;
      end else if (cons_en && (cons_cnt > best_total_ff ||
                               (cons_cnt == best_total_ff && cons_idx < best_idx_ff))) begin
         best_total_in = cons_cnt;
         best_idx_in   = cons_idx;
         best_key_in   = cons_key;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         cnt_mem[wr_addr] <= wr_cnt;
         en_mem[wr_addr]  <= wr_en_sum;
         rev_mem[wr_addr] <= wr_rev;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         cnt_rd_ff <= cnt_mem[rd_addr];
         en_rd_ff  <= en_mem[rd_addr];
         rev_rd_ff <= rev_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      prod_ff     <= prod_in;
      scan_ff     <= scan_in;
      nc_ff       <= nc_in;
      ne_ff       <= ne_in;
      nr_ff       <= nr_in;
      best_key_ff <= best_key_in;
      st_ff       <= st_in;
      eidx_ff     <= eidx_in;
      ekey_ff     <= ekey_in;
      ecnt_ff     <= ecnt_in;
      een_ff      <= een_in;
      erev_ff     <= erev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pgba_pkg::ENG_IDLE;
         stored_ff     <= '0;
         best_total_ff <= '0;
         best_idx_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         stored_ff     <= stored_in;
         best_total_ff <= best_total_in;
         best_idx_ff   <= best_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.status        = st_ff;
   assign rsp_ch.entry_index   = eidx_ff;
   assign rsp_ch.pair_total    = 10'(stored_ff);
   assign rsp_ch.entry_buyer   = ekey_ff[31:16];
   assign rsp_ch.entry_seller  = ekey_ff[15:0];
   assign rsp_ch.entry_count   = ecnt_ff;
   assign rsp_ch.entry_energy  = een_ff;
   assign rsp_ch.entry_revenue = erev_ff;
   assign rsp_ch.best_buyer    = (best_total_ff != '0) ? best_key_ff[31:16] : '0;
   assign rsp_ch.best_seller   = (best_total_ff != '0) ? best_key_ff[15:0] : '0;
   assign rsp_ch.best_count    = best_total_ff;

`ifndef SYNTHESIS
   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= SW'(TABLE_DEPTH))
      else $error("pair count beyond table depth");

   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !rsp_valid_ff && state_ff == pgba_pkg::ENG_IDLE)
      else $error("command taken while response pending");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == pgba_pkg::ENG_WRITE || state_ff == pgba_pkg::ENG_APPEND)
      else $error("table write outside update");

   a_best_stored: assert property (@(posedge clock) disable iff (reset)
      best_total_ff != '0 |-> SW'(best_idx_ff) < stored_ff)
      else $error("best entry not stored");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == pgba_pkg::ENG_APPEND |=> stored_ff == $past(stored_ff) + SW'(1))
      else $error("append did not grow table");
`endif

endmodule

/* rtl/core/pair_group_by_aggregate_top.sv */
// top level of the pair group-by aggregation block
//
//  channel  dir  ports                      handshake
//  req_ch   in   action .. read_index       valid / ready
//  rsp_ch   out  status .. best_count       valid / ready
//
// clear is handled in the idle state; read checks the index, then waits for the table read;
// accumulate reads then compares each stored key over the table memory read port, then updates, appends or reports full
// a two-entry command queue keeps taking requests while a response waits, until the queue is full
// the engine takes the next queued request in the cycle after its response is accepted
// synchronous active-high reset empties the table; no clearing pass is needed
module pair_group_by_aggregate_top #(
   parameter int TABLE_DEPTH = pgba_pkg::TABLE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pgba_req_if.sink   req_ch,
   pgba_rsp_if.source rsp_ch
);

   logic              cmd_valid;
   logic              cmd_pop;
   pgba_pkg::cmd_type cmd;

   pgba_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   pgba_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
